>>> src/swcp_pkg.sv
// Package for the square wave channel pair unit.
// Holds item codes, register offsets, duty patterns and the length load table.
// No dependencies.
`default_nettype none

package swcp_pkg;

    // Default number of tone channels.
    localparam int CHANNELS_DEFAULT = 2;

    // Item kinds carried on the func field.
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TIMER = 2'd1;
    localparam logic [1:0] FUNC_FRAME = 2'd2;

    // Shared register offsets.
    localparam logic [4:0] ADDR_ENABLE = 5'h15;
    localparam logic [4:0] ADDR_FRAME  = 5'h17;

    // Offsets within one channel's register group.
    localparam logic [1:0] SUB_CONTROL = 2'd0;
    localparam logic [1:0] SUB_PERIOD_LO = 2'd2;
    localparam logic [1:0] SUB_PERIOD_HI = 2'd3;

    // Eight-step duty patterns, bit n is the output for step n.
    localparam logic [7:0] DUTY_PATTERNS [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};

    // Length counter load values.
    localparam logic [7:0] LENGTH_TABLE [32] = '{
        8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
        8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

endpackage

`default_nettype wire

>>> src/square_wave_channel_pair_unit.sv
// Square wave channel pair unit: tone channels, frame sequencer, level output.
// Depends on swcp_pkg for item codes, register offsets and tables.
//
// Usage: each input item on the s_ channel is a register write, a channel
// timer tick or a frame sequencer tick. Every accepted item yields exactly one
// result item on the m_ channel with the first two channel levels and their sum.
// Latency: the result is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver does not stall. The channel
// state is updated by one level of combinational logic at the accept edge and
// the result lands in an output register in the same edge.
// When the receiver stalls, the output register holds its result and s_ready
// stays high only if that result is taken in the same cycle.
// Reset (aresetn low, synchronous) clears all channel and sequencer state,
// selects four step frame mode and empties the output register.
`default_nettype none

module square_wave_channel_pair_unit #(
    parameter int CHANNELS = swcp_pkg::CHANNELS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [4:0] s_reg_addr,
    input  wire logic [7:0] s_reg_value,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_level_one,
    output logic [3:0]      m_level_two,
    output logic [4:0]      m_mix_sum
);

    // Channel state.
    logic [10:0] period_reg [CHANNELS];
    logic [10:0] period_next [CHANNELS];
    logic [10:0] timer_reg [CHANNELS];
    logic [10:0] timer_next [CHANNELS];
    logic [2:0]  step_reg [CHANNELS];
    logic [2:0]  step_next [CHANNELS];
    logic [1:0]  duty_reg [CHANNELS];
    logic [1:0]  duty_next [CHANNELS];
    logic [3:0]  volume_reg [CHANNELS];
    logic [3:0]  volume_next [CHANNELS];
    logic        len_en_reg [CHANNELS];
    logic        len_en_next [CHANNELS];
    logic        ch_en_reg [CHANNELS];
    logic        ch_en_next [CHANNELS];
    logic [7:0]  len_count_reg [CHANNELS];
    logic [7:0]  len_count_next [CHANNELS];
    logic [3:0]  held_reg [CHANNELS];
    logic [3:0]  held_next [CHANNELS];

    // Frame sequencer state.
    logic       frame_mode_reg;
    logic       frame_mode_next;
    logic [2:0] frame_step_reg;
    logic [2:0] frame_step_next;

    // Output register.
    logic       m_valid_reg;
    logic [3:0] level_one_reg;
    logic [3:0] level_two_reg;
    logic [4:0] mix_sum_reg;

    logic       accept;
    logic [2:0] frame_last;
    logic [2:0] frame_pos;
    logic       clock_len;
    logic [3:0] level_one_c;
    logic [3:0] level_two_c;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Frame sequencer step decode.
    always_comb begin
        frame_last = frame_mode_reg ? 3'd4 : 3'd3;
        frame_pos  = (frame_step_reg > frame_last) ? frame_last : frame_step_reg;
        if (frame_mode_reg) begin
            clock_len = (frame_pos == 3'd0) || (frame_pos == 3'd2);
        end else begin
            clock_len = (frame_pos == 3'd1) || (frame_pos == 3'd3);
        end
    end

    // Next state for one item, followed by the level gating.
    always_comb begin
        frame_mode_next = frame_mode_reg;
        frame_step_next = frame_step_reg;
        for (int c = 0; c < CHANNELS; c++) begin
            period_next[c]    = period_reg[c];
            timer_next[c]     = timer_reg[c];
            step_next[c]      = step_reg[c];
            duty_next[c]      = duty_reg[c];
            volume_next[c]    = volume_reg[c];
            len_en_next[c]    = len_en_reg[c];
            ch_en_next[c]     = ch_en_reg[c];
            len_count_next[c] = len_count_reg[c];
            held_next[c]      = held_reg[c];
        end

        if (accept) begin
            case (s_func)
                swcp_pkg::FUNC_WRITE: begin
                    if (s_reg_addr == swcp_pkg::ADDR_ENABLE) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            ch_en_next[c] = s_reg_value[c];
                        end
                    end else if (s_reg_addr == swcp_pkg::ADDR_FRAME) begin
                        frame_mode_next = s_reg_value[7];
                        frame_step_next = 3'd0;
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (s_reg_addr[4:2] == 3'(c)) begin
                                case (s_reg_addr[1:0])
                                    swcp_pkg::SUB_CONTROL: begin
                                        duty_next[c]   = s_reg_value[7:6];
                                        len_en_next[c] = s_reg_value[5];
                                        volume_next[c] = s_reg_value[4] ?
                                                         s_reg_value[3:0] : 4'd0;
                                    end
                                    swcp_pkg::SUB_PERIOD_LO: begin
                                        period_next[c] = {period_reg[c][10:8],
                                                          s_reg_value};
                                        timer_next[c]  = period_next[c];
                                    end
                                    swcp_pkg::SUB_PERIOD_HI: begin
                                        period_next[c] = {s_reg_value[2:0],
                                                          period_reg[c][7:0]};
                                        timer_next[c]  = period_next[c];
                                        if (len_en_reg[c]) begin
                                            len_count_next[c] =
                                                swcp_pkg::LENGTH_TABLE[s_reg_value[7:3]];
                                        end
                                        step_next[c] = 3'd0;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
                swcp_pkg::FUNC_TIMER: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (len_en_reg[c]) begin
                            if (timer_reg[c] <= 11'd1) begin
                                timer_next[c] = period_reg[c];
                                held_next[c]  =
                                    swcp_pkg::DUTY_PATTERNS[duty_reg[c]][step_reg[c]] ?
                                    volume_reg[c] : 4'd0;
                                step_next[c]  = step_reg[c] + 3'd1;
                            end else begin
                                timer_next[c] = timer_reg[c] - 11'd1;
                            end
                        end
                    end
                end
                swcp_pkg::FUNC_FRAME: begin
                    if (clock_len) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (ch_en_reg[c] && (len_count_reg[c] != 8'd0)) begin
                                len_count_next[c] = len_count_reg[c] - 8'd1;
                            end
                        end
                    end
                    frame_step_next = (frame_pos >= frame_last) ? 3'd0 :
                                      frame_pos + 3'd1;
                end
                default: ;
            endcase
        end

        // Silence a channel that is disabled, expired or has a stopped timer.
        for (int c = 0; c < CHANNELS; c++) begin
            if (!len_en_next[c] || !ch_en_next[c] ||
                (len_count_next[c] == 8'd0) || (timer_next[c] == 11'd0)) begin
                held_next[c] = 4'd0;
            end
        end
    end

    // Pick the reported levels; a missing second channel reads as zero.
    always_comb begin
        level_one_c = held_next[0];
        level_two_c = 4'd0;
        for (int c = 1; c < CHANNELS; c++) begin
            if (c == 1) begin
                level_two_c = held_next[c];
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= 1'b0;
            frame_step_reg <= 3'd0;
            for (int c = 0; c < CHANNELS; c++) begin
                period_reg[c]    <= '0;
                timer_reg[c]     <= '0;
                step_reg[c]      <= '0;
                duty_reg[c]      <= '0;
                volume_reg[c]    <= '0;
                len_en_reg[c]    <= 1'b0;
                ch_en_reg[c]     <= 1'b0;
                len_count_reg[c] <= '0;
                held_reg[c]      <= '0;
            end
        end else begin
            frame_mode_reg <= frame_mode_next;
            frame_step_reg <= frame_step_next;
            for (int c = 0; c < CHANNELS; c++) begin
                period_reg[c]    <= period_next[c];
                timer_reg[c]     <= timer_next[c];
                step_reg[c]      <= step_next[c];
                duty_reg[c]      <= duty_next[c];
                volume_reg[c]    <= volume_next[c];
                len_en_reg[c]    <= len_en_next[c];
                ch_en_reg[c]     <= ch_en_next[c];
                len_count_reg[c] <= len_count_next[c];
                held_reg[c]      <= held_next[c];
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            level_one_reg <= level_one_c;
            level_two_reg <= level_two_c;
            mix_sum_reg   <= {1'b0, level_one_c} + {1'b0, level_two_c};
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_level_one = level_one_reg;
    assign m_level_two = level_two_reg;
    assign m_mix_sum   = mix_sum_reg;

endmodule

`default_nettype wire
